FILE: rtl/bfei_pkg.sv
package bfei_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_INSERT  = 2'd3
  } op_e;

  // one image word is eight bytes, a field window is two words
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WIN_BITS  = 2 * WORD_BITS;
  localparam logic [6:0]  BYTE_BITS = 7'd8;
  localparam logic [7:0]  WIN_COUNT = 8'd128;

  // decoded request held between the read and the write-back cycle
  typedef struct packed {
    op_e         op;
    logic        lo_odd;   // low word of the window sits in the odd bank
    logic [5:0]  shift;    // bit position inside the low word
    logic [6:0]  len;      // field length after clamping
    logic [7:0]  vcnt;     // window bits that lie inside the image
    logic [63:0] value;
  } exec_t;

endpackage

FILE: rtl/bfei_bank.sv
module bfei_bank #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bfei_decode.sv
module bfei_decode #(
  parameter int unsigned IMAGE_BYTES    = 1024,
  parameter int unsigned MAX_FIELD_BITS = 64,
  parameter int unsigned ROWS           = 64,
  parameter int unsigned RAW            = 6
) (
  input  logic [1:0]     operation_i,
  input  logic [9:0]     byte_address_i,
  input  logic [15:0]    bit_offset_i,
  input  logic [6:0]     bit_length_i,
  input  logic [63:0]    field_value_i,
  input  logic [10:0]    image_size_i,
  output bfei_pkg::exec_t req_o,
  output logic [RAW-1:0] even_row_o,
  output logic [RAW-1:0] odd_row_o,
  output logic           even_ok_o,
  output logic           odd_ok_o
);
  import bfei_pkg::*;

  op_e         op;
  logic        byte_op;
  logic [15:0] pos;
  logic [9:0]  word;
  logic [9:0]  even_full;
  logic [9:0]  odd_full;
  logic [13:0] limit;
  logic [16:0] lim_bits;
  logic [16:0] base;
  logic [16:0] diff;
  logic        byte_in;
  logic [7:0]  field_vcnt;
  logic [6:0]  field_len;

  // bit position of the access, byte requests are byte aligned
  assign op      = op_e'(operation_i);
  assign byte_op = (op == OP_LOAD) || (op == OP_READ);
  assign pos     = byte_op ? {3'b0, byte_address_i, 3'b0} : bit_offset_i;
  assign word    = pos[15:6];

  // word w and w+1 always fall in different banks
  assign even_full  = 10'(({1'b0, word} + 11'd1) >> 1);
  assign odd_full   = {1'b0, word[9:1]};
  assign even_ok_o  = {22'b0, even_full} < 32'(ROWS);
  assign odd_ok_o   = {22'b0, odd_full} < 32'(ROWS);
  assign even_row_o = even_ok_o ? RAW'(even_full) : '0;
  assign odd_row_o  = odd_ok_o ? RAW'(odd_full) : '0;

  // how many window bits lie below the active image end
  assign limit    = ({21'b0, image_size_i} > 32'(IMAGE_BYTES)) ? 14'(IMAGE_BYTES)
                                                               : {3'b0, image_size_i};
  assign lim_bits = {limit, 3'b0};
  assign base     = {1'b0, word, 6'b0};
  assign diff     = lim_bits - base;

  always_comb begin
    if (lim_bits <= base) begin
      field_vcnt = '0;
    end else if (diff >= {9'b0, WIN_COUNT}) begin
      field_vcnt = WIN_COUNT;
    end else begin
      field_vcnt = diff[7:0];
    end
  end

  // byte requests only check the store size
  assign byte_in   = {22'b0, byte_address_i} < 32'(IMAGE_BYTES);
  assign field_len = (bit_length_i > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS) : bit_length_i;

  always_comb begin
    req_o.op     = op;
    req_o.lo_odd = word[0];
    req_o.shift  = pos[5:0];
    req_o.len    = byte_op ? BYTE_BITS : field_len;
    req_o.vcnt   = byte_op ? (byte_in ? WIN_COUNT : 8'd0) : field_vcnt;
    req_o.value  = field_value_i;
  end

endmodule

FILE: rtl/bfei_merge.sv
module bfei_merge (
  input  bfei_pkg::exec_t req_i,
  input  logic [63:0]     even_i,
  input  logic [63:0]     odd_i,
  output logic [63:0]     data_o,
  output logic [63:0]     even_o,
  output logic [63:0]     odd_o
);
  import bfei_pkg::*;

  logic [WIN_BITS-1:0]  win;
  logic [WIN_BITS-1:0]  vmask;
  logic [WORD_BITS-1:0] lmask;
  logic [WIN_BITS-1:0]  wmask;
  logic [WIN_BITS-1:0]  ext;
  logic [WIN_BITS-1:0]  nwin;

  // two-word window, low word first
  assign win = req_i.lo_odd ? {even_i, odd_i} : {odd_i, even_i};

  // in-image bits and field bits
  assign vmask = ~({WIN_BITS{1'b1}} << req_i.vcnt);
  assign lmask = ~({WORD_BITS{1'b1}} << req_i.len);
  assign wmask = ({{WORD_BITS{1'b0}}, lmask} << req_i.shift) & vmask;

  // extract, out-of-image bits read as zero
  assign ext = (win & vmask) >> req_i.shift;

  always_comb begin
    case (req_i.op) inside
      OP_READ, OP_EXTRACT: data_o = ext[WORD_BITS-1:0] & lmask;
      default:             data_o = '0;
    endcase
  end

  // insert, other image bits kept
  assign nwin = (win & ~wmask) | (({{WORD_BITS{1'b0}}, req_i.value} << req_i.shift) & wmask);

  assign even_o = req_i.lo_odd ? nwin[WIN_BITS-1:WORD_BITS] : nwin[WORD_BITS-1:0];
  assign odd_o  = req_i.lo_odd ? nwin[WORD_BITS-1:0] : nwin[WIN_BITS-1:WORD_BITS];

endmodule

FILE: rtl/bit_field_extract_insert_core.sv
// channel   | ports                                                      | dir
// ----------+------------------------------------------------------------+----
// request   | start, busy, operation_i, byte_address_i, bit_offset_i,    | in
//           | bit_length_i, field_value_i                                |
// result    | done_o, data_o                                             | out
// config    | cfg_we_i, cfg_wdata_i (image_size)                         | in
//
// both image banks are read at acceptance, the window is merged and
// written back in the next cycle, and done_o is registered from the
// merge while the next request may already be accepted.
// after reset the banks are cleared one row a cycle, with busy high;
// config writes are taken always.
// the result is a one-cycle strobe and cannot be held off.
module bit_field_extract_insert_core #(
  parameter int unsigned IMAGE_BYTES    = 1024,
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  byte_address_i,
  input  logic [15:0] bit_offset_i,
  input  logic [6:0]  bit_length_i,
  input  logic [63:0] field_value_i,
  output logic        done_o,
  output logic [63:0] data_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);
  import bfei_pkg::*;

  localparam int unsigned WORDS = (IMAGE_BYTES + 7) / 8;
  localparam int unsigned ROWS  = (WORDS + 1) / 2;
  localparam int unsigned RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e         state_q;
  logic [RAW-1:0] clr_row_q;
  logic [10:0]    image_size_q;
  logic           done_q;
  logic [63:0]    data_q;

  exec_t          req_d;
  exec_t          req_q;
  logic [RAW-1:0] even_row_d, odd_row_d;
  logic [RAW-1:0] even_row_q, odd_row_q;
  logic           even_ok_d, odd_ok_d;
  logic           even_ok_q, odd_ok_q;

  logic           accept;
  logic           clearing;
  logic           wr_op;
  logic [63:0]    even_rd, odd_rd;
  logic [63:0]    even_new, odd_new;
  logic [63:0]    merge_data;
  logic           even_we, odd_we;
  logic [RAW-1:0] even_waddr, odd_waddr;
  logic [63:0]    even_wdata, odd_wdata;

  // handshake, busy interlocks reads against the pending write-back
  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign clearing = (state_q == ST_CLEAR);
  assign wr_op    = (req_q.op == OP_LOAD) || (req_q.op == OP_INSERT);

  // request decode
  bfei_decode #(
    .IMAGE_BYTES    (IMAGE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .ROWS           (ROWS),
    .RAW            (RAW)
  ) u_decode (
    .operation_i    (operation_i),
    .byte_address_i (byte_address_i),
    .bit_offset_i   (bit_offset_i),
    .bit_length_i   (bit_length_i),
    .field_value_i  (field_value_i),
    .image_size_i   (image_size_q),
    .req_o          (req_d),
    .even_row_o     (even_row_d),
    .odd_row_o      (odd_row_d),
    .even_ok_o      (even_ok_d),
    .odd_ok_o       (odd_ok_d)
  );

  // write port muxing, clearing pass or write-back
  assign even_we    = clearing || ((state_q == ST_EXEC) && wr_op && even_ok_q);
  assign odd_we     = clearing || ((state_q == ST_EXEC) && wr_op && odd_ok_q);
  assign even_waddr = clearing ? clr_row_q : even_row_q;
  assign odd_waddr  = clearing ? clr_row_q : odd_row_q;
  assign even_wdata = clearing ? '0 : even_new;
  assign odd_wdata  = clearing ? '0 : odd_new;

  // image banks, even and odd words
  bfei_bank #(
    .DEPTH (ROWS),
    .AW    (RAW)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_waddr),
    .wdata_i (even_wdata),
    .re_i    (accept),
    .raddr_i (even_row_d),
    .rdata_o (even_rd)
  );

  bfei_bank #(
    .DEPTH (ROWS),
    .AW    (RAW)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_waddr),
    .wdata_i (odd_wdata),
    .re_i    (accept),
    .raddr_i (odd_row_d),
    .rdata_o (odd_rd)
  );

  // extract and insert on the fetched window
  bfei_merge u_merge (
    .req_i  (req_q),
    .even_i (even_rd),
    .odd_i  (odd_rd),
    .data_o (merge_data),
    .even_o (even_new),
    .odd_o  (odd_new)
  );

  // request hold registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_d;
      even_row_q <= even_row_d;
      odd_row_q  <= odd_row_d;
      even_ok_q  <= even_ok_d;
      odd_ok_q   <= odd_ok_d;
    end
  end

  // sequencer, clearing pass, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_row_q    <= '0;
      image_size_q <= 11'd1024;
      done_q       <= 1'b0;
      data_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        image_size_q <= cfg_wdata_i;
      end
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_row_q <= clr_row_q + RAW'(1);
          if (clr_row_q == RAW'(ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done_q  <= 1'b1;
          data_q  <= merge_data;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign data_o = data_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import bfei_pkg::*;

  localparam int unsigned IMAGE_BYTES    = 1024;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned DRAIN_LIMIT    = 10000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  operation_i;
  logic [9:0]  byte_address_i;
  logic [15:0] bit_offset_i;
  logic [6:0]  bit_length_i;
  logic [63:0] field_value_i;
  logic        done_o;
  logic [63:0] data_o;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;

  // mirror of the process image and of the size register
  logic [7:0]  image_mirror [IMAGE_BYTES];
  logic [10:0] image_size_mirror;
  logic [63:0] expected_data [$];

  int unsigned max_gap       = 19;
  int unsigned error_count   = 0;
  int unsigned result_count  = 0;
  int unsigned size_writes   = 0;
  int unsigned request_count [4] = '{0, 0, 0, 0};

  bit_field_extract_insert_core #(
    .IMAGE_BYTES    (IMAGE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .byte_address_i (byte_address_i),
    .bit_offset_i   (bit_offset_i),
    .bit_length_i   (bit_length_i),
    .field_value_i  (field_value_i),
    .done_o         (done_o),
    .data_o         (data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // apply one request to the mirror and return the data it reads
  function automatic logic [63:0] apply_request(op_e op, logic [9:0] addr,
      logic [15:0] offset, logic [6:0] length, logic [63:0] value);
    logic [63:0] data;
    int unsigned limit;
    int unsigned count;
    int unsigned pos;
    data  = '0;
    limit = (image_size_mirror > IMAGE_BYTES) ? IMAGE_BYTES : image_size_mirror;
    count = (length > MAX_FIELD_BITS) ? MAX_FIELD_BITS : length;
    case (op)
      // a 10-bit address always lies inside the store
      OP_LOAD: begin
        image_mirror[addr] = value[7:0];
      end
      OP_READ: begin
        data = {56'd0, image_mirror[addr]};
      end
      default: begin
        // lsb-first walk, stopping at the first byte past the image size
        for (int i = 0; i < count; i++) begin
          pos = offset + i;
          if (pos / 8 >= limit) break;
          if (op == OP_EXTRACT) data[i] = image_mirror[pos / 8][pos % 8];
          else image_mirror[pos / 8][pos % 8] = value[i];
        end
      end
    endcase
    return data;
  endfunction

  // check each result, then predict the request taken at this edge
  always @(posedge clk_i) begin
    logic [63:0] want;
    logic [63:0] predicted;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        result_count++;
        if (expected_data.size() == 0) begin
          $error("data_o: result with no request outstanding, actual %h", data_o);
          error_count++;
        end else begin
          want = expected_data.pop_front();
          if (data_o !== want) begin
            $error("data_o: expected %h, actual %h", want, data_o);
            error_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        request_count[operation_i]++;
        predicted = apply_request(op_e'(operation_i), byte_address_i,
                                  bit_offset_i, bit_length_i, field_value_i);
        expected_data = {expected_data, predicted};
      end
    end
  end

  // issue one request after a random gap, return at the edge that takes it
  task automatic send_request(op_e op, logic [9:0] addr, logic [15:0] offset,
      logic [6:0] length, logic [63:0] value);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= op;
    byte_address_i <= addr;
    bit_offset_i   <= offset;
    bit_length_i   <= length;
    field_value_i  <= value;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // stop sending until every outstanding result is back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    for (int k = 0; k < DRAIN_LIMIT && expected_data.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_image_size(logic [10:0] size);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    image_size_mirror = size;
    size_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // image reads as zero once the clearing pass is over
  task automatic test_cleared_image();
    send_request(OP_READ, 10'd0, 16'd0, 7'd0, 64'd0);
    send_request(OP_EXTRACT, 10'd0, 16'd0, 7'd64, 64'd0);
  endtask

  // byte load and read at both ends and in the middle of the store
  task automatic test_byte_access();
    send_request(OP_LOAD, 10'd0, 16'hffff, 7'd127, 64'hffff_ffff_ffff_ffa5);
    send_request(OP_LOAD, 10'd1023, 16'd0, 7'd0, 64'h0000_0000_0000_005a);
    send_request(OP_READ, 10'd0, 16'd0, 7'd0, 64'd0);
    send_request(OP_READ, 10'd1023, 16'hffff, 7'd127, 64'hffff_ffff_ffff_ffff);
    send_request(OP_LOAD, 10'h2aa, 16'd0, 7'd0, 64'h0000_0000_0000_00c3);
    send_request(OP_READ, 10'h2aa, 16'd0, 7'd0, 64'd0);
  endtask

  // field lengths 0, 64 and clamped, unaligned spans, the image end
  task automatic test_field_extremes();
    send_request(OP_INSERT, 10'd0, 16'd0, 7'd64, 64'hfedc_ba98_7654_3210);
    send_request(OP_EXTRACT, 10'd0, 16'd0, 7'd64, 64'd0);
    send_request(OP_EXTRACT, 10'd0, 16'd4, 7'd0, 64'd0);
    send_request(OP_INSERT, 10'd0, 16'd3, 7'd0, 64'hffff_ffff_ffff_ffff);
    send_request(OP_EXTRACT, 10'd0, 16'd0, 7'd127, 64'd0);
    send_request(OP_INSERT, 10'd0, 16'd61, 7'd7, 64'h0000_0000_0000_0055);
    send_request(OP_EXTRACT, 10'd0, 16'd56, 7'd16, 64'd0);
    send_request(OP_INSERT, 10'd0, 16'd8131, 7'd64, 64'hffff_ffff_ffff_ffff);
    send_request(OP_EXTRACT, 10'd0, 16'd8131, 7'd127, 64'd0);
    send_request(OP_READ, 10'd1023, 16'd0, 7'd0, 64'd0);
    send_request(OP_INSERT, 10'd0, 16'hffff, 7'd64, 64'hffff_ffff_ffff_ffff);
    send_request(OP_EXTRACT, 10'd0, 16'hffff, 7'd64, 64'd0);
  endtask

  // oversized, tiny and empty image
  task automatic test_image_size_edges();
    write_image_size(11'd2047);
    send_request(OP_EXTRACT, 10'd0, 16'd8131, 7'd64, 64'd0);
    write_image_size(11'd3);
    send_request(OP_INSERT, 10'd0, 16'd16, 7'd32, 64'hffff_ffff_ffff_ffff);
    send_request(OP_EXTRACT, 10'd0, 16'd0, 7'd64, 64'd0);
    send_request(OP_READ, 10'd3, 16'd0, 7'd0, 64'd0);
    write_image_size(11'd0);
    send_request(OP_INSERT, 10'd0, 16'd0, 7'd64, 64'd0);
    send_request(OP_EXTRACT, 10'd0, 16'd0, 7'd64, 64'd0);
    send_request(OP_READ, 10'd0, 16'd0, 7'd0, 64'd0);
  endtask

  // random requests, inserts mostly followed by an extract of the same field
  task automatic test_random_traffic(int unsigned items);
    op_e         op;
    logic [9:0]  addr;
    logic [15:0] offset;
    logic [6:0]  length;
    logic [63:0] value;
    int unsigned bits_in_use;
    int unsigned sent;
    bits_in_use = ((image_size_mirror > IMAGE_BYTES) ? IMAGE_BYTES : image_size_mirror) * 8;
    sent = 0;
    while (sent < items) begin
      op = op_e'($urandom_range(0, 3));
      // mostly inside the image or across its end, now and then anywhere
      if ($urandom_range(0, 9) < 8) offset = 16'($urandom_range(0, bits_in_use + 72));
      else offset = 16'($urandom());
      if ($urandom_range(0, 7) == 0) length = 7'($urandom_range(65, 127));
      else length = 7'($urandom_range(0, 64));
      if (bits_in_use != 0 && $urandom_range(0, 1) == 0)
        addr = 10'($urandom_range(0, bits_in_use / 8 - 1));
      else addr = 10'($urandom());
      value = {$urandom(), $urandom()};
      send_request(op, addr, offset, length, value);
      sent++;
      if (op == OP_INSERT && $urandom_range(0, 3) != 0) begin
        send_request(OP_EXTRACT, addr, offset, length, 64'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    logic [10:0] sizes [8];
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = OP_LOAD;
    byte_address_i = '0;
    bit_offset_i   = '0;
    bit_length_i   = '0;
    field_value_i  = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    image_size_mirror = 11'd1024;
    foreach (image_mirror[a]) image_mirror[a] = 8'h00;
    sizes = '{11'd1024, 11'd2047, 11'd0, 11'd1, 11'd3, 11'd1023,
              11'($urandom_range(0, 2047)), 11'($urandom_range(0, 1024))};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cleared_image();
    test_byte_access();
    test_field_extremes();
    test_image_size_edges();
    // every third phase runs back to back
    foreach (sizes[p]) begin
      write_image_size(sizes[p]);
      max_gap = (p % 3 == 1) ? 0 : 19;
      test_random_traffic(250);
    end

    wait_idle();
    if (expected_data.size() != 0) begin
      $error("data_o: %0d results never arrived", expected_data.size());
      error_count++;
    end
    $display("tb: %0d requests (%0d load, %0d read, %0d extract, %0d insert), %0d results",
             request_count[OP_LOAD] + request_count[OP_READ] + request_count[OP_EXTRACT]
             + request_count[OP_INSERT], request_count[OP_LOAD], request_count[OP_READ],
             request_count[OP_EXTRACT], request_count[OP_INSERT], result_count);
    $display("tb: %0d image size writes from 0 to 2047, lengths 0 to 127, gaps 0 to 19",
             size_writes);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bfei_pkg.sv
rtl/bfei_bank.sv
rtl/bfei_decode.sv
rtl/bfei_merge.sv
rtl/bit_field_extract_insert_core.sv
tb/tb.sv
